/* src/msl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants of the multi-stack linked pool unit.
// ----------------------------------------------------------------------------
package msl_pkg;

  // Fixed field widths of a request and a response
  localparam int unsigned ValW = 32;
  localparam int unsigned SelW = 3;

  // Operation codes carried by req_type
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the request and issue the pool read
    logic commit;  // apply the update and load the response register
  } ctrl_cmd_t;

endpackage

/* src/msl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_req_if / msl_rsp_if
// Valid/ready channels for requests and responses of the pool unit.
// ----------------------------------------------------------------------------
interface msl_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [msl_pkg::SelW-1:0]       stack_select;
  logic signed [msl_pkg::ValW-1:0] push_value;

  modport source (output valid, output req_type, output stack_select,
                  output push_value, input ready);
  modport sink   (input valid, input req_type, input stack_select,
                  input push_value, output ready);
endinterface

interface msl_rsp_if;
  logic                            valid;
  logic                            ready;
  logic signed [msl_pkg::ValW-1:0] pop_value;
  logic [1:0]                      status;
  logic                            stack_empty;

  modport source (output valid, output pop_value, output status,
                  output stack_empty, input ready);
  modport sink   (input valid, input pop_value, input status,
                  input stack_empty, output ready);
endinterface

/* src/multi_stack_linked_pool_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_stack_linked_pool_unit
// Several LIFO stacks kept as linked lists over one shared node pool.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per transaction: push push_value onto the
//   stack named by stack_select, or pop its top. rsp_o returns exactly one
//   response transaction per request with pop_value, a status (ok, pop from
//   empty stack, pool full) and whether the stack is empty afterwards.
//   Sequencing: an accepted request issues the registered pool read and
//   moves the controller to S_EXEC; from there, once the response register
//   is free, the update commits and the response is raised.
//   Overlap: no new request is taken until the previous one commits; the
//   pool memory's registered read of the node comes before its write.
//   Reset: all stacks empty, free list empty, no node handed out. Pool
//   contents are not cleared; only written nodes are ever read.
//   Stall: a pending response holds while rsp_o.ready is low; one further
//   request is taken and waits, after its read, until the response register
//   drains.
// ----------------------------------------------------------------------------
module multi_stack_linked_pool_unit #(
  parameter int unsigned NUM_STACKS = 8,
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  msl_req_if.sink   req_i,
  msl_rsp_if.source rsp_o
);

  msl_pkg::ctrl_cmd_t cmd;

  msl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  msl_dp #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_i.req_type),
    .stack_select_i (req_i.stack_select),
    .push_value_i   (req_i.push_value),
    .pop_value_o    (rsp_o.pop_value),
    .status_o       (rsp_o.status),
    .stack_empty_o  (rsp_o.stack_empty)
  );

endmodule

/* src/msl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/msl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_dp
// Datapath: stack top pointers, free list head, bump counter, node pool
// memory and the response payload register.
// ----------------------------------------------------------------------------
module msl_dp #(
  parameter int unsigned NUM_STACKS = 8,
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  msl_pkg::ctrl_cmd_t              cmd_i,
  input  logic                            req_type_i,
  input  logic [msl_pkg::SelW-1:0]        stack_select_i,
  input  logic signed [msl_pkg::ValW-1:0] push_value_i,
  output logic signed [msl_pkg::ValW-1:0] pop_value_o,
  output logic [1:0]                      status_o,
  output logic                            stack_empty_o
);

  // Only stacks reachable through the select field get storage
  localparam int unsigned MaxSel = 1 << msl_pkg::SelW;
  localparam int unsigned StkCnt = (NUM_STACKS < MaxSel) ? NUM_STACKS : MaxSel;
  localparam int unsigned SW     = (StkCnt > 1) ? $clog2(StkCnt) : 1;
  localparam int unsigned AW     = $clog2(POOL_DEPTH);
  localparam int unsigned PW     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned VW     = msl_pkg::ValW;
  localparam int unsigned RW     = VW + PW;
  localparam logic [PW-1:0] NullPtr = PW'(POOL_DEPTH);
  localparam logic [msl_pkg::SelW:0] NumStk = (msl_pkg::SelW + 1)'(StkCnt);

  // Pointer state
  logic [PW-1:0] top_q [StkCnt];
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] unused_q, unused_d;

  // Captured request
  logic                   pop_q;
  logic                   sel_ok_q;
  logic [SW-1:0]          idx_q;
  logic [VW-1:0]          val_q;

  // Response payload
  logic [VW-1:0]          pop_value_q, pop_value_d;
  logic [1:0]             status_q, status_d;
  logic                   empty_q, empty_d;

  // Accept-side lookup
  logic                   sel_ok_in;
  logic [SW-1:0]          idx_in;
  logic [PW-1:0]          top_in;
  logic [PW-1:0]          rd_ptr;
  logic                   rd_en;

  // Execute-side signals
  logic [PW-1:0]          top_cur;
  logic [RW-1:0]          rdata;
  logic [VW-1:0]          rd_val;
  logic [PW-1:0]          rd_next;
  logic                   top_we;
  logic [PW-1:0]          top_new;
  logic                   wr_en;
  logic [PW-1:0]          wr_ptr;
  logic [RW-1:0]          wdata;

  // Look up the addressed top and pick the node to read
  always_comb begin
    sel_ok_in = ({1'b0, stack_select_i} < NumStk);
    idx_in    = stack_select_i[SW-1:0];
    top_in    = sel_ok_in ? top_q[idx_in] : NullPtr;
    rd_ptr    = (req_type_i == msl_pkg::OP_POP) ? top_in : free_head_q;
    rd_en     = cmd_i.load && sel_ok_in && (rd_ptr != NullPtr);
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_q    <= (req_type_i == msl_pkg::OP_POP);
      sel_ok_q <= sel_ok_in;
      idx_q    <= idx_in;
      val_q    <= push_value_i;
    end
  end

  msl_ram #(
    .WIDTH (RW),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_ptr[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_ptr[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_val  = rdata[RW-1:PW];
  assign rd_next = rdata[PW-1:0];

  // Resolve the operation once the node has been read
  always_comb begin
    top_cur     = sel_ok_q ? top_q[idx_q] : NullPtr;
    free_head_d = free_head_q;
    unused_d    = unused_q;
    top_we      = 1'b0;
    top_new     = top_cur;
    wr_en       = 1'b0;
    wr_ptr      = top_cur;
    wdata       = {val_q, top_cur};
    pop_value_d = '0;
    status_d    = msl_pkg::ST_OK;
    empty_d     = 1'b1;
    priority if (!sel_ok_q) begin
      status_d = pop_q ? msl_pkg::ST_EMPTY : msl_pkg::ST_FULL;
    end else if (pop_q) begin
      if (top_cur == NullPtr) begin
        status_d = msl_pkg::ST_EMPTY;
      end else begin
        // Unlink the top node and return it to the free list
        pop_value_d = rd_val;
        top_we      = 1'b1;
        top_new     = rd_next;
        wr_en       = 1'b1;
        wr_ptr      = top_cur;
        wdata       = {rd_val, free_head_q};
        free_head_d = top_cur;
        empty_d     = (rd_next == NullPtr);
      end
    end else if (free_head_q != NullPtr) begin
      // Reuse the free list head
      free_head_d = rd_next;
      top_we      = 1'b1;
      top_new     = free_head_q;
      wr_en       = 1'b1;
      wr_ptr      = free_head_q;
      empty_d     = 1'b0;
    end else if (unused_q < NullPtr) begin
      // Hand out a fresh node
      unused_d = unused_q + PW'(1);
      top_we   = 1'b1;
      top_new  = unused_q;
      wr_en    = 1'b1;
      wr_ptr   = unused_q;
      empty_d  = 1'b0;
    end else begin
      status_d = msl_pkg::ST_FULL;
      empty_d  = (top_cur == NullPtr);
    end
    if (!cmd_i.commit) begin
      wr_en = 1'b0;
    end
  end

  // Update pointer state on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < StkCnt; k++) begin
        top_q[k] <= NullPtr;
      end
      free_head_q <= NullPtr;
      unused_q    <= '0;
    end else if (cmd_i.commit) begin
      if (top_we) begin
        top_q[idx_q] <= top_new;
      end
      free_head_q <= free_head_d;
      unused_q    <= unused_d;
    end
  end

  // Load the response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pop_value_q <= pop_value_d;
      status_q    <= status_d;
      empty_q     <= empty_d;
    end
  end

  assign pop_value_o   = pop_value_q;
  assign status_o      = status_q;
  assign stack_empty_o = empty_q;

endmodule

/* src/msl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_ctrl
// Controller: takes one request at a time, sequences the pool read and the
// update, and owns the response valid flag.
// ----------------------------------------------------------------------------
module msl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msl_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // Response slot frees up when empty or taken this cycle
  assign slot_free    = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == S_IDLE);
  assign cmd_o.load   = in_ready_o && in_valid_i;
  assign cmd_o.commit = (state_q == S_EXEC) && slot_free;
  assign out_valid_o  = out_valid_q;

  // State and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/msl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msl_checker
// Port-level checks of the pool unit, bound to the top level.
// ----------------------------------------------------------------------------
module msl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] pop_value_i,
  input logic [1:0]  status_i,
  input logic        stack_empty_i
);

  // One request in flight: no back-to-back acceptance
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while previous one still in work");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(pop_value_i) && $stable(status_i)
       && $stable(stack_empty_i)))
    else $error("stalled response changed");

  // Failed pop reports an empty stack and no value
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == msl_pkg::ST_EMPTY) |->
      (pop_value_i == '0 && stack_empty_i))
    else $error("failed pop with value or non-empty flag");

  // Only defined status codes, and no value on a full pool
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == msl_pkg::ST_OK || status_i == msl_pkg::ST_EMPTY
                     || (status_i == msl_pkg::ST_FULL && pop_value_i == '0)))
    else $error("bad status or value on pool full");

endmodule

bind multi_stack_linked_pool_unit msl_checker u_msl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .pop_value_i   (rsp_o.pop_value),
  .status_i      (rsp_o.status),
  .stack_empty_i (rsp_o.stack_empty)
);
